// File: hw/rtl/mbrm_pkg.sv
// ----------------------------------------------------------------------------
// mbrm_pkg: Modbus RTU read master shared definitions
// Command and result codes, field widths and the CRC-16 byte step.
// ----------------------------------------------------------------------------
package mbrm_pkg;

  localparam int CMD_W      = 2;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 56;  // 5 fields, 56 bits, already whole bytes
  localparam int OUT_DATA_W = 48;  // 41 field bits padded to 6 bytes

  localparam int FRAME_LEN = 8;
  localparam int CRC_SPAN  = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_REQUEST = 2'd0,
    CMD_RX_BYTE = 2'd1,
    CMD_TICK    = 2'd2
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_TX      = 2'd0,
    KIND_VALUE   = 2'd1,
    KIND_TIMEOUT = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REPLY_ADDRESS = 2'd0,
    REG_TIMEOUT_TICKS = 2'd1
  } cfg_reg_t;

  localparam logic [7:0]  REPLY_ADDRESS_RESET = 8'd1;
  localparam logic [7:0]  TIMEOUT_TICKS_RESET = 8'd200;
  localparam logic [15:0] CRC_INIT            = 16'hFFFF;
  localparam logic [15:0] CRC_POLY            = 16'hA001;
  localparam logic [7:0]  COUNT_TWO           = 8'd2;
  localparam logic [7:0]  COUNT_FOUR          = 8'd4;

  // Fold one byte into the reflected Modbus CRC-16.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'd0, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/modbus_rtu_read_master_unit.sv
// ----------------------------------------------------------------------------
// modbus_rtu_read_master_unit: Modbus RTU read-holding-registers master
// Builds request frames with CRC-16, parses the reply and runs the timeout.
// ----------------------------------------------------------------------------
// A request word yields eight transmit words on the output stream, one per
// cycle while the output is not stalled: the first leaves in the cycle after
// the request is taken from the input register, and the CRC is folded in one
// byte per transmit word as the header bytes go out. Received-byte and tick
// words are not taken while a frame is in flight; those that give no result
// pass even while the output is stalled. An input register and the output
// register part the two sides, so a new word is taken while a result waits.
// Configuration writes are always ready and must be made while the block is
// idle.
module modbus_rtu_read_master_unit (
  input  logic                           clk,
  input  logic                           rst,
  // slave side
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [7:0] slave_addr, [15:8] function_code, [31:16] reg_addr,
  // [47:32] word_count, [55:48] rx_byte
  input  logic [mbrm_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic [mbrm_pkg::CMD_W-1:0]     s_axis_tuser,   // [1:0] cmd
  // master side
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] tx_byte, [39:8] value, [40] four_byte, [47:41] zero
  output logic [mbrm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [mbrm_pkg::KIND_W-1:0]    m_axis_tuser,   // [1:0] kind
  output logic                           m_axis_tlast,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mbrm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);
  import mbrm_pkg::*;

  typedef enum logic [2:0] {
    PH_ADDR  = 3'd0,
    PH_FUNC  = 3'd1,
    PH_COUNT = 3'd2,
    PH_DATA  = 3'd3,
    PH_CRC   = 3'd4
  } phase_t;

  localparam logic [2:0] CRC_LO_POS = 3'(CRC_SPAN);
  localparam logic [2:0] LAST_POS   = 3'(FRAME_LEN - 1);

  // configuration
  logic [7:0] reply_address;
  logic [7:0] timeout_ticks;

  // input register
  logic                 in_valid;
  logic [CMD_W-1:0]     in_cmd;
  logic [IN_DATA_W-1:0] in_data;

  // parser and timeout state
  phase_t      parse_phase, parse_phase_next;
  logic [2:0]  byte_position, byte_position_next;
  logic [31:0] data_shift, data_shift_next;
  logic        count_is_four, count_is_four_next;
  logic        awaiting_reply, awaiting_reply_next;
  logic [7:0]  ticks_left, ticks_left_next;

  // frame generator
  logic        frame_active;
  logic [2:0]  frame_pos;
  logic [39:0] frame_shift;
  logic [15:0] crc;

  // output register
  logic        out_valid;
  kind_t       out_kind;
  logic [7:0]  out_tx;
  logic [31:0] out_value;
  logic        out_four;
  logic        out_last;

  // item decode
  logic        out_free;
  logic        consume;
  logic        start_frame;
  logic        item_emit;
  kind_t       item_kind;
  logic [31:0] item_value;
  logic        item_four;
  logic [7:0]  in_slave_addr;
  logic [7:0]  in_rx_byte;
  logic [7:0]  frame_byte;
  logic [2:0]  data_bytes;

  assign in_slave_addr = in_data[7:0];
  assign in_rx_byte    = in_data[55:48];

  assign out_free      = !out_valid || m_axis_tready;
  assign consume       = in_valid && !frame_active &&
                         (out_free || !(item_emit || start_frame));
  assign s_axis_tready = !in_valid || consume;
  assign cfg_ready     = 1'b1;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {7'd0, out_four, out_value, out_tx};

  assign data_bytes = count_is_four ? 3'd4 : 3'd2;

  always_comb begin
    parse_phase_next    = parse_phase;
    byte_position_next  = byte_position;
    data_shift_next     = data_shift;
    count_is_four_next  = count_is_four;
    awaiting_reply_next = awaiting_reply;
    ticks_left_next     = ticks_left;
    start_frame         = 1'b0;
    item_emit           = 1'b0;
    item_kind           = KIND_TX;
    item_value          = 32'd0;
    item_four           = 1'b0;
    case (in_cmd)
      CMD_REQUEST: begin
        start_frame         = 1'b1;
        parse_phase_next    = PH_ADDR;
        byte_position_next  = 3'd0;
        data_shift_next     = 32'd0;
        count_is_four_next  = 1'b0;
        awaiting_reply_next = 1'b1;
        ticks_left_next     = timeout_ticks;
      end
      CMD_RX_BYTE: begin
        if (awaiting_reply) begin
          case (parse_phase)
            PH_ADDR: begin
              if (in_rx_byte == reply_address) begin
                parse_phase_next = PH_FUNC;
              end
            end
            PH_FUNC: begin
              parse_phase_next = PH_COUNT;
            end
            PH_COUNT: begin
              if (in_rx_byte == COUNT_TWO || in_rx_byte == COUNT_FOUR) begin
                count_is_four_next = (in_rx_byte == COUNT_FOUR);
                byte_position_next = 3'd0;
                data_shift_next    = 32'd0;
                parse_phase_next   = PH_DATA;
              end
            end
            PH_DATA: begin
              data_shift_next = {data_shift[23:0], in_rx_byte};
              if (byte_position + 3'd1 >= data_bytes) begin
                byte_position_next = 3'd0;
                parse_phase_next   = PH_CRC;
              end else begin
                byte_position_next = byte_position + 3'd1;
              end
            end
            default: begin
              byte_position_next = byte_position + 3'd1;
              if (byte_position_next >= 3'd2) begin
                item_emit           = 1'b1;
                item_kind           = KIND_VALUE;
                item_four           = count_is_four;
                item_value          = count_is_four ? data_shift
                                    : {{16{data_shift[15]}}, data_shift[15:0]};
                parse_phase_next    = PH_ADDR;
                byte_position_next  = 3'd0;
                data_shift_next     = 32'd0;
                count_is_four_next  = 1'b0;
                awaiting_reply_next = 1'b0;
                ticks_left_next     = 8'd0;
              end
            end
          endcase
        end
      end
      CMD_TICK: begin
        if (awaiting_reply) begin
          if (ticks_left <= 8'd1) begin
            item_emit           = 1'b1;
            item_kind           = KIND_TIMEOUT;
            ticks_left_next     = 8'd0;
            awaiting_reply_next = 1'b0;
            parse_phase_next    = PH_ADDR;
            byte_position_next  = 3'd0;
            data_shift_next     = 32'd0;
            count_is_four_next  = 1'b0;
          end else begin
            ticks_left_next = ticks_left - 8'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // next frame byte: header bytes from the shift line, then CRC low, high
  always_comb begin
    if (frame_pos < CRC_LO_POS) begin
      frame_byte = frame_shift[39:32];
    end else if (frame_pos == CRC_LO_POS) begin
      frame_byte = crc[7:0];
    end else begin
      frame_byte = crc[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_address  <= REPLY_ADDRESS_RESET;
      timeout_ticks  <= TIMEOUT_TICKS_RESET;
      in_valid       <= 1'b0;
      parse_phase    <= PH_ADDR;
      byte_position  <= 3'd0;
      data_shift     <= 32'd0;
      count_is_four  <= 1'b0;
      awaiting_reply <= 1'b0;
      ticks_left     <= 8'd0;
      frame_active   <= 1'b0;
      frame_pos      <= 3'd0;
      out_valid      <= 1'b0;
      out_kind       <= KIND_TX;
      out_last       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_REPLY_ADDRESS: reply_address <= cfg_data;
          REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
          default: begin
          end
        endcase
      end

      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
        in_cmd   <= s_axis_tuser;
        in_data  <= s_axis_tdata;
      end

      if (frame_active) begin
        if (out_free) begin
          out_valid <= 1'b1;
          out_kind  <= KIND_TX;
          out_tx    <= frame_byte;
          out_value <= 32'd0;
          out_four  <= 1'b0;
          out_last  <= (frame_pos == LAST_POS);
          if (frame_pos < CRC_LO_POS) begin
            crc         <= crc_byte(crc, frame_shift[39:32]);
            frame_shift <= {frame_shift[31:0], 8'd0};
          end
          frame_pos <= frame_pos + 3'd1;
          if (frame_pos == LAST_POS) begin
            frame_active <= 1'b0;
          end
        end
      end else begin
        if (consume) begin
          parse_phase    <= parse_phase_next;
          byte_position  <= byte_position_next;
          data_shift     <= data_shift_next;
          count_is_four  <= count_is_four_next;
          awaiting_reply <= awaiting_reply_next;
          ticks_left     <= ticks_left_next;
        end
        if (consume && start_frame) begin
          // send the address now, queue the rest of the header
          out_valid    <= 1'b1;
          out_kind     <= KIND_TX;
          out_tx       <= in_slave_addr;
          out_value    <= 32'd0;
          out_four     <= 1'b0;
          out_last     <= 1'b0;
          crc          <= crc_byte(CRC_INIT, in_slave_addr);
          frame_shift  <= {in_data[15:8], in_data[31:24], in_data[23:16],
                           in_data[47:40], in_data[39:32]};
          frame_pos    <= 3'd1;
          frame_active <= 1'b1;
        end else if (consume && item_emit) begin
          out_valid <= 1'b1;
          out_kind  <= item_kind;
          out_tx    <= 8'd0;
          out_value <= item_value;
          out_four  <= item_four;
          out_last  <= 1'b1;
        end else if (out_free) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  // a frame in flight always has a byte parked in the output register
  a_frame_has_word: assert property (@(posedge clk) disable iff (rst)
    frame_active |-> out_valid)
    else $error("frame active with empty output register");

  a_frame_mid_word: assert property (@(posedge clk) disable iff (rst)
    frame_active |-> (out_kind == KIND_TX && !out_last))
    else $error("non-final transmit word expected while frame active");

  a_frame_awaits: assert property (@(posedge clk) disable iff (rst)
    frame_active |-> awaiting_reply)
    else $error("frame sent without waiting for reply");

  a_header_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (parse_phase == PH_ADDR || parse_phase == PH_FUNC || parse_phase == PH_COUNT)
      |-> byte_position == 3'd0)
    else $error("byte position set outside data and CRC phases");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != KIND_TX) |-> m_axis_tlast)
    else $error("value or timeout word without last");

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the Modbus RTU read master unit
// Walks a short table of requests, reply bytes and ticks, then runs random
// request/reply exchanges under several register settings. Results are
// predicted per accepted word and compared in order, with bursty input,
// output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import mbrm_pkg::*;

  localparam logic [1:0] CMD_UNUSED      = 2'd3;
  localparam int         N_DIR           = 28;
  localparam int         N_PHASES        = 5;
  localparam int         WORDS_PER_PHASE = 70;
  localparam int         SETTLE_CYCLES   = 12;
  localparam int         LONG_HOLD       = 600;
  localparam int         STALL_LIMIT     = 3000;

  typedef enum logic [2:0] {
    PH_ADDR, PH_FUNC, PH_COUNT, PH_DATA, PH_CRC
  } rx_phase_t;

  typedef enum {ROW_WORD, ROW_SET_REPLY, ROW_SET_TIMEOUT} row_kind_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  slave_addr;
    logic [7:0]  function_code;
    logic [15:0] reg_addr;
    logic [15:0] word_count;
    logic [7:0]  rx_byte;
  } word_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  tx;
    logic [31:0] value;
    logic        four;
    logic        last;
  } result_t;

  // nexp: -1 predicted, 0 no result, 1 the single result typed in the row;
  // register rows carry the write data in the rx column
  typedef struct {
    row_kind_t   rk;
    logic [1:0]  cmd;
    logic [7:0]  sa;
    logic [7:0]  fc;
    logic [15:0] ra;
    logic [15:0] cnt;
    logic [7:0]  rx;
    int          nexp;
    kind_t       ekind;
    logic [31:0] evalue;
    logic        efour;
  } dir_row_t;

  dir_row_t dir_tbl [N_DIR] = '{
    '{ROW_WORD, CMD_RX_BYTE, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h01, 0, KIND_TX, 32'h0, 1'b0},
    '{ROW_WORD, CMD_TICK,    8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 0, KIND_TX, 32'h0, 1'b0},
    '{ROW_WORD, CMD_UNUSED,  8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 0, KIND_TX, 32'h0, 1'b0},
    '{ROW_WORD, CMD_REQUEST, 8'h01, 8'h03, 16'h0000, 16'h0001, 8'h00, -1, KIND_TX, 32'h0, 1'b0},
    '{ROW_WORD, CMD_RX_BYTE, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h07, 0, KIND_TX, 32'h0, 1'b0},
    '{ROW_WORD, CMD_RX_BYTE, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h01, 0, KIND_TX, 32'h0, 1'b0},
    '{ROW_WORD, CMD_RX_BYTE, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h03, 0, KIND_TX, 32'h0, 1'b0},
    '{ROW_WORD, CMD_RX_BYTE, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h03, 0, KIND_TX, 32'h0, 1'b0},
    '{ROW_WORD, CMD_RX_BYTE, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h02, 0, KIND_TX, 32'h0, 1'b0},
    '{ROW_WORD, CMD_RX_BYTE, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h80, 0, KIND_TX, 32'h0, 1'b0},
    '{ROW_WORD, CMD_RX_BYTE, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 0, KIND_TX, 32'h0, 1'b0},
    '{ROW_WORD, CMD_RX_BYTE, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'hAA, 0, KIND_TX, 32'h0, 1'b0},
    '{ROW_WORD, CMD_RX_BYTE, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h55, 1,
      KIND_VALUE, 32'hFFFF8000, 1'b0},
    '{ROW_WORD, CMD_REQUEST, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'h00, -1, KIND_TX, 32'h0, 1'b0},
    '{ROW_WORD, CMD_REQUEST, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, -1, KIND_TX, 32'h0, 1'b0},
    '{ROW_WORD, CMD_RX_BYTE, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h01, 0, KIND_TX, 32'h0, 1'b0},
    '{ROW_WORD, CMD_RX_BYTE, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'hFF, 0, KIND_TX, 32'h0, 1'b0},
    '{ROW_WORD, CMD_RX_BYTE, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h04, 0, KIND_TX, 32'h0, 1'b0},
    '{ROW_WORD, CMD_RX_BYTE, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h7F, 0, KIND_TX, 32'h0, 1'b0},
    '{ROW_WORD, CMD_RX_BYTE, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'hFF, 0, KIND_TX, 32'h0, 1'b0},
    '{ROW_WORD, CMD_RX_BYTE, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'hFF, 0, KIND_TX, 32'h0, 1'b0},
    '{ROW_WORD, CMD_RX_BYTE, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'hFF, 0, KIND_TX, 32'h0, 1'b0},
    '{ROW_WORD, CMD_RX_BYTE, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 0, KIND_TX, 32'h0, 1'b0},
    '{ROW_WORD, CMD_RX_BYTE, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'hFF, 1,
      KIND_VALUE, 32'h7FFFFFFF, 1'b1},
    '{ROW_SET_TIMEOUT, CMD_REQUEST, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 0,
      KIND_TX, 32'h0, 1'b0},
    '{ROW_SET_REPLY, CMD_REQUEST, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 0,
      KIND_TX, 32'h0, 1'b0},
    '{ROW_WORD, CMD_REQUEST, 8'h5A, 8'h03, 16'h1234, 16'h0002, 8'h00, -1, KIND_TX, 32'h0, 1'b0},
    '{ROW_WORD, CMD_TICK,    8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 1,
      KIND_TIMEOUT, 32'h0, 1'b0}
  };

  logic                  clk;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // slave_addr, function_code, reg_addr,
                                               // word_count, rx_byte
  logic [CMD_W-1:0]      s_axis_tuser  = '0;  // cmd
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // tx_byte, value, four_byte, zero pad
  logic [KIND_W-1:0]     m_axis_tuser;        // kind
  logic                  m_axis_tlast;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [7:0]            cfg_data      = '0;

  // predictor state and register copies
  logic [7:0]  reply_addr;
  logic [7:0]  timeout_reg;
  rx_phase_t   rx_phase;
  logic [3:0]  byte_pos;
  logic [31:0] data_shift;
  logic        count4;
  logic        waiting_reply;
  logic [7:0]  ticks_left;

  result_t pending_results [$];
  int      n_err         = 0;
  int      counted_words = 0;
  int      burst_left    = 0;
  bit      gaps_on       = 1'b1;
  bit      hold_go       = 1'b0;
  bit      hold_done     = 1'b0;
  int      quiet         = 0;

  modbus_rtu_read_master_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // bitwise form of the reflected CRC-16
  function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] x;
    logic        fb;
    x = c;
    for (int b = 0; b < 8; b++) begin
      fb = x[0] ^ d[b];
      x  = x >> 1;
      if (fb) begin
        x = x ^ CRC_POLY;
      end
    end
    return x;
  endfunction

  function automatic void clear_parser();
    rx_phase   = PH_ADDR;
    byte_pos   = '0;
    data_shift = '0;
    count4     = 1'b0;
  endfunction

  // Advance the predicted state by one word; queue its results when keep is set.
  function automatic void master_outputs(input word_t w, input bit keep);
    logic [7:0]  frame [FRAME_LEN];
    logic [15:0] crc;
    logic [31:0] v;
    result_t     r;
    case (w.cmd)
      CMD_REQUEST: begin
        frame = '{w.slave_addr, w.function_code, w.reg_addr[15:8], w.reg_addr[7:0],
                  w.word_count[15:8], w.word_count[7:0], 8'h00, 8'h00};
        crc = CRC_INIT;
        for (int i = 0; i < CRC_SPAN; i++) begin
          crc = crc_fold(crc, frame[i]);
        end
        frame[6] = crc[7:0];
        frame[7] = crc[15:8];
        for (int i = 0; i < FRAME_LEN; i++) begin
          r = '{KIND_TX, frame[i], 32'h0, 1'b0, i == FRAME_LEN - 1};
          if (keep) pending_results.push_back(r);
        end
        clear_parser();
        waiting_reply = 1'b1;
        ticks_left    = timeout_reg;
      end
      CMD_RX_BYTE: if (waiting_reply) begin
        case (rx_phase)
          PH_ADDR: if (w.rx_byte == reply_addr) rx_phase = PH_FUNC;
          PH_FUNC: rx_phase = PH_COUNT;
          PH_COUNT: if (w.rx_byte == COUNT_TWO || w.rx_byte == COUNT_FOUR) begin
            count4     = (w.rx_byte == COUNT_FOUR);
            byte_pos   = '0;
            data_shift = '0;
            rx_phase   = PH_DATA;
          end
          PH_DATA: begin
            data_shift = {data_shift[23:0], w.rx_byte};
            byte_pos   = byte_pos + 4'd1;
            if (byte_pos >= (count4 ? 4'd4 : 4'd2)) begin
              byte_pos = '0;
              rx_phase = PH_CRC;
            end
          end
          default: begin
            byte_pos = byte_pos + 4'd1;
            if (byte_pos >= 4'd2) begin
              v = count4 ? data_shift : {{16{data_shift[15]}}, data_shift[15:0]};
              r = '{KIND_VALUE, 8'h00, v, count4, 1'b1};
              if (keep) pending_results.push_back(r);
              clear_parser();
              waiting_reply = 1'b0;
              ticks_left    = '0;
            end
          end
        endcase
      end
      CMD_TICK: if (waiting_reply) begin
        if (ticks_left <= 8'd1) begin
          ticks_left    = '0;
          waiting_reply = 1'b0;
          clear_parser();
          r = '{KIND_TIMEOUT, 8'h00, 32'h0, 1'b0, 1'b1};
          if (keep) pending_results.push_back(r);
        end else begin
          ticks_left = ticks_left - 8'd1;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_word(input word_t w, input bit keep);
    if (burst_left == 0) begin
      if (gaps_on) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w.rx_byte, w.word_count, w.reg_addr, w.function_code, w.slave_addr};
    s_axis_tuser  <= w.cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    master_outputs(w, keep);
  endtask

  task automatic issue(input word_t w);
    send_word(w, 1'b1);
    counted_words++;
  endtask

  function automatic word_t random_word(input logic [1:0] cmd);
    word_t w;
    w.cmd           = cmd;
    w.slave_addr    = 8'($urandom_range(0, 255));
    w.function_code = 8'($urandom_range(0, 255));
    w.reg_addr      = 16'($urandom_range(0, 65535));
    w.word_count    = 16'($urandom_range(0, 65535));
    w.rx_byte       = 8'($urandom_range(0, 255));
    return w;
  endfunction

  // Leaves cfg_valid high; the caller drops it after its last write.
  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_REPLY_ADDRESS) reply_addr = d;
    else timeout_reg = d;
  endtask

  // Stop offering, wait out every queued result, then let in-flight words drain.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One request and a reply built around it: stray addresses, bad counts,
  // interleaved ticks, and now and then an abandoned reply or a timeout.
  task automatic run_exchange();
    word_t      w;
    logic [7:0] reply [$];
    logic [7:0] b;
    int         fate;
    int         n_data;
    int         stop_at;
    w = random_word(CMD_REQUEST);
    if ($urandom_range(0, 3) != 0) w.function_code = 8'd3;
    issue(w);
    fate = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        b = 8'($urandom_range(0, 255));
        if (b == reply_addr) b = ~b;
        reply.push_back(b);
      end
    end
    reply.push_back(reply_addr);
    reply.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) == 0) begin
      b = 8'($urandom_range(0, 255));
      if (b == COUNT_TWO || b == COUNT_FOUR) b = b + 8'd1;
      reply.push_back(b);
    end
    n_data = $urandom_range(0, 1) ? 4 : 2;
    reply.push_back(n_data[7:0]);
    repeat (n_data + 2) reply.push_back(8'($urandom_range(0, 255)));
    stop_at = reply.size();
    if (fate == 0) stop_at = $urandom_range(0, reply.size() - 1);
    if (fate == 1 && timeout_reg <= 8'd16) begin
      stop_at = 0;
      while (waiting_reply) issue(random_word(CMD_TICK));
    end
    for (int k = 0; k < stop_at; k++) begin
      if ($urandom_range(0, 5) == 0) issue(random_word(CMD_TICK));
      w = random_word(CMD_RX_BYTE);
      w.rx_byte = reply[k];
      issue(w);
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      n_err++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        n_err++;
        $display("%0t: word with nothing expected, expected none, got kind %0d data %h",
                 $time, m_axis_tuser, m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
        check_field("tx_byte", 32'(want.tx), 32'(m_axis_tdata[7:0]));
        check_field("value", want.value, m_axis_tdata[39:8]);
        check_field("four_byte", 32'(want.four), 32'(m_axis_tdata[40]));
        check_field("last", 32'(want.last), 32'(m_axis_tlast));
      end
    end
  end

  // output side: a stall pattern picked at random, plus one long hold
  initial begin
    int cyc;
    int mode;
    cyc  = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        if (cyc % 64 == 0) mode = $urandom_range(0, 2);
        cyc++;
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= !m_axis_tready;
        endcase
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet == STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    word_t      w;
    dir_row_t   row;
    logic [7:0] new_reply;
    logic [7:0] new_timeout;
    reply_addr    = REPLY_ADDRESS_RESET;
    timeout_reg   = TIMEOUT_TICKS_RESET;
    waiting_reply = 1'b0;
    ticks_left    = '0;
    clear_parser();
    rst <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIR; i++) begin
      row = dir_tbl[i];
      if (row.rk == ROW_WORD) begin
        w = '{row.cmd, row.sa, row.fc, row.ra, row.cnt, row.rx};
        send_word(w, row.nexp < 0);
        if (row.nexp > 0) begin
          pending_results.push_back('{row.ekind, 8'h00, row.evalue, row.efour, 1'b1});
        end
      end else begin
        if (i == 0 || dir_tbl[i-1].rk == ROW_WORD) settle();
        write_reg(row.rk == ROW_SET_REPLY ? REG_REPLY_ADDRESS : REG_TIMEOUT_TICKS, row.rx);
        if (i == N_DIR - 1 || dir_tbl[i+1].rk == ROW_WORD) cfg_valid <= 1'b0;
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      case (p)
        0: begin
          new_reply   = 8'h00;
          new_timeout = 8'd255;
        end
        1: begin
          new_reply   = 8'hFF;
          new_timeout = 8'd1;
        end
        2: begin
          new_reply   = 8'($urandom_range(0, 255));
          new_timeout = 8'($urandom_range(2, 12));
        end
        3: begin
          new_reply   = 8'($urandom_range(0, 255));
          new_timeout = TIMEOUT_TICKS_RESET;
        end
        default: begin
          new_reply   = REPLY_ADDRESS_RESET;
          new_timeout = 8'($urandom_range(1, 255));
        end
      endcase
      write_reg(REG_REPLY_ADDRESS, new_reply);
      write_reg(REG_TIMEOUT_TICKS, new_timeout);
      cfg_valid <= 1'b0;
      // one phase with back-to-back input, one with the output held off
      gaps_on = (p != 3);
      if (p == 2) hold_go = 1'b1;
      counted_words = 0;
      while (counted_words < WORDS_PER_PHASE) begin
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) issue(random_word(2'($urandom_range(0, 3))));
        end
        run_exchange();
      end
    end

    settle();
    if (n_err == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
